// File: rtl/core/apq_pkg.sv
package apq_pkg;

	localparam int DEPTH_DEF = 128;
	localparam int VALUE_W   = 32;
	localparam int COUNT_W   = 8;

	// operation codes carried on the op port
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SCAN_WAIT,
		S_SHIFT_INIT,
		S_SHIFT,
		S_SHIFT_WAIT,
		S_FINISH
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic    capture;
		logic    scan_init;
		logic    shift_init;
		logic    issue;
		logic    issue_scan;
		logic    ins_write;
		logic    held_inc;
		logic    held_dec;
		logic    res_load;
		logic    res_best;
		status_t res_status;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic op_remove;
		logic full;
		logic empty;
		logic last;
		logic no_shift;
	} sts_t;

endpackage

// File: rtl/core/apq_ctrl.sv
module apq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  apq_pkg::sts_t sts,
	output apq_pkg::cmd_t cmd,
	output logic          busy
);
	import apq_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_nxt = S_DECODE;
			end
			S_DECODE: begin
				if (sts.op_remove && !sts.empty) state_nxt = S_SCAN;
				else state_nxt = S_IDLE;
			end
			S_SCAN: begin
				if (sts.last) state_nxt = S_SCAN_WAIT;
			end
			S_SCAN_WAIT: begin
				state_nxt = S_SHIFT_INIT;
			end
			S_SHIFT_INIT: begin
				if (sts.no_shift) state_nxt = S_FINISH;
				else state_nxt = S_SHIFT;
			end
			S_SHIFT: begin
				if (sts.last) state_nxt = S_SHIFT_WAIT;
			end
			S_SHIFT_WAIT: begin
				state_nxt = S_FINISH;
			end
			S_FINISH: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.res_status = STS_OK;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = start;
			end
			S_DECODE: begin
				if (!sts.op_remove) begin
					cmd.res_load = 1'b1;
					if (sts.full) begin
						cmd.res_status = STS_FULL;
					end else begin
						cmd.ins_write = 1'b1;
						cmd.held_inc  = 1'b1;
					end
				end else if (sts.empty) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = STS_EMPTY;
				end else begin
					cmd.scan_init = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.issue      = 1'b1;
				cmd.issue_scan = 1'b1;
			end
			S_SHIFT_INIT: begin
				cmd.shift_init = 1'b1;
			end
			S_SHIFT: begin
				cmd.issue = 1'b1;
			end
			S_FINISH: begin
				cmd.res_load = 1'b1;
				cmd.res_best = 1'b1;
				cmd.held_dec = 1'b1;
			end
			default: begin
				cmd.res_status = STS_OK;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: rtl/core/apq_dpath.sv
module apq_dpath #(
	parameter int DEPTH = apq_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                op,
	input  logic signed [apq_pkg::VALUE_W-1:0]  value,
	input  apq_pkg::cmd_t                       cmd,
	output apq_pkg::sts_t                       sts,
	output logic                                done,
	output logic [1:0]                          status,
	output logic signed [apq_pkg::VALUE_W-1:0]  removed,
	output logic [apq_pkg::COUNT_W-1:0]         count,
	output logic                                empty_res
);
	import apq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int HW = $clog2(DEPTH + 1);

	logic signed [VALUE_W-1:0] mem [DEPTH];

	logic                      op_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [HW-1:0]             held_q;
	logic [HW-1:0]             held_nxt;
	logic [HW+COUNT_W-1:0]     held_ext;
	logic [AW-1:0]             ptr_q;
	logic [AW-1:0]             best_idx_q;
	logic signed [VALUE_W-1:0] best_val_q;

	logic                      vld_s1;
	logic                      scan_s1;
	logic [AW-1:0]             idx_s1;
	logic signed [VALUE_W-1:0] rd_data_s1;

	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic signed [VALUE_W-1:0] wr_data;

	logic                      done_q;
	logic [1:0]                status_q;
	logic signed [VALUE_W-1:0] removed_q;
	logic [COUNT_W-1:0]        count_q;
	logic                      empty_q;

	// memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_s1 <= mem[ptr_q];
	end

	// insert writes the tail; a shift read returns and lands one slot lower
	always_comb begin
		wr_en   = cmd.ins_write || (vld_s1 && !scan_s1);
		wr_addr = cmd.ins_write ? held_q[AW-1:0] : (idx_s1 - AW'(1));
		wr_data = cmd.ins_write ? value_q : rd_data_s1;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op;
			value_q <= value;
		end
		idx_s1  <= ptr_q;
		scan_s1 <= cmd.issue_scan;
		if (vld_s1 && scan_s1) begin
			if ((idx_s1 == '0) || (rd_data_s1 > best_val_q)) begin
				best_val_q <= rd_data_s1;
				best_idx_q <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			ptr_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			held_q <= held_nxt;
			vld_s1 <= cmd.issue;
			if (cmd.scan_init) begin
				ptr_q <= '0;
			end else if (cmd.shift_init) begin
				ptr_q <= best_idx_q + AW'(1);
			end else if (cmd.issue) begin
				ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	always_comb begin
		held_nxt = held_q;
		if (cmd.held_inc) held_nxt = held_q + HW'(1);
		else if (cmd.held_dec) held_nxt = held_q - HW'(1);
	end

	assign held_ext = {{COUNT_W{1'b0}}, held_nxt};

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q  <= cmd.res_status;
			removed_q <= cmd.res_best ? best_val_q : '1;
			count_q   <= held_ext[COUNT_W-1:0];
			empty_q   <= (held_nxt == '0);
		end
	end

	assign sts.op_remove = (op_q == OP_REMOVE);
	assign sts.full      = (held_q == HW'(DEPTH));
	assign sts.empty     = (held_q == '0);
	assign sts.last      = ((HW'(ptr_q) + HW'(1)) == held_q);
	assign sts.no_shift  = ((HW'(best_idx_q) + HW'(1)) == held_q);

	assign done      = done_q;
	assign status    = status_q;
	assign removed   = removed_q;
	assign count     = count_q;
	assign empty_res = empty_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HW'(DEPTH))
		else $error("held count above depth");

	a_dec_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.held_dec |-> (held_q != '0))
		else $error("remove completed on an empty store");

	a_inc_notfull: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.held_inc |-> (held_q != HW'(DEPTH)))
		else $error("insert completed on a full store");

	a_shift_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !scan_s1) |-> (idx_s1 != '0))
		else $error("shift write below slot zero");

endmodule

// File: rtl/core/array_max_priority_queue.sv
// Channel   | Ports                              | Handshake
// ----------+------------------------------------+---------------------------------
// command   | op, value                          | taken when start & !busy
// result    | status, removed, count, empty_res  | valid for the one cycle done is high
//
// Every transaction gives exactly one result. For an insert or a refused remove the result
// registers load from the decode state, and done is registered alongside them.
// A remove reads the held entries one a cycle through the memory read port: it scans all
// of them for the maximum at slot b, then shifts the entries above b down one slot; the
// shift is skipped when b is the last slot.
// busy is low while done is high, so the next transaction may be taken in that cycle.
// arst_n clears the controller, the held count and the strobes; the store itself is not
// cleared, only entries already written are ever read.
// The receiver cannot stall: each result is shown for a single cycle only.
module array_max_priority_queue #(
	parameter int DEPTH = apq_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                op,
	input  logic signed [apq_pkg::VALUE_W-1:0]  value,
	output logic                                done,
	output logic [1:0]                          status,
	output logic signed [apq_pkg::VALUE_W-1:0]  removed,
	output logic [apq_pkg::COUNT_W-1:0]         count,
	output logic                                empty_res
);
	import apq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequence the transaction: decode, scan for the maximum, shift the tail down
	apq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// hold the store, the count, the running maximum and the result registers
	apq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.status    (status),
		.removed   (removed),
		.count     (count),
		.empty_res (empty_res)
	);

endmodule
